// File: sv/mcw_pkg.sv
// Shared types and constants of the Markov chain walker.
package mcw_pkg;

  // Chain geometry and fixed-point format.
  localparam int NUM_STATES = 256;
  localparam int MAX_EDGES  = 8;
  localparam int PROB_BITS  = 16;

  localparam int STATE_W   = $clog2(NUM_STATES);
  localparam int EDGE_IDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CNT_W     = $clog2(MAX_EDGES + 1);
  localparam int FRAC_W    = PROB_BITS + 1;
  localparam int SCORE_W   = PROB_BITS + 2;
  localparam int EDGE_ADDR_W = STATE_W + EDGE_IDX_W;
  localparam int EDGE_DEPTH  = NUM_STATES * (2 ** EDGE_IDX_W);
  localparam int HDR_W     = CNT_W + SCORE_W;
  localparam int EDGE_W    = STATE_W + SCORE_W;

  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
  localparam logic [CNT_W-1:0]   CNT_FULL  = CNT_W'(MAX_EDGES);

  // Request opcodes.
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_STEP   = 1'b1;

  // Input request and result payloads.
  typedef struct packed {
    logic        opcode;
    logic [7:0]  source_state;
    logic [7:0]  dest_state;
    logic [16:0] edge_prob;
    logic [16:0] rand_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] next_state;
    logic       no_match;
    logic       load_rejected;
  } out_item_t;

  // Controller states, one-hot.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_HDR  = 5'b00010,
    S_EVAL = 5'b00100,
    S_SCAN = 5'b01000,
    S_DONE = 5'b10000
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic eval;
    logic scan;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic opcode;
    logic scan_hit;
    logic scan_end;
    logic out_busy;
  } ctrl_sts_t;

endpackage

// File: sv/mcw_ram.sv
// Generic simple dual-port RAM with registered read data.
module mcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/mcw_ctrl.sv
// Controller state machine of the Markov chain walker.
module mcw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mcw_pkg::ctrl_sts_t sts,
  output mcw_pkg::ctrl_cmd_t cmd
);

  mcw_pkg::ctrl_state_t state_r, state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_stall     = 1'b1;
    case (state_r)
      mcw_pkg::S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = mcw_pkg::S_HDR;
        end
      end
      mcw_pkg::S_HDR: begin
        state_nxt = mcw_pkg::S_EVAL;
      end
      mcw_pkg::S_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.opcode == mcw_pkg::OP_STEP) begin
          state_nxt = mcw_pkg::S_SCAN;
        end else begin
          state_nxt = mcw_pkg::S_DONE;
        end
      end
      mcw_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_hit || sts.scan_end) begin
          state_nxt = mcw_pkg::S_DONE;
        end
      end
      mcw_pkg::S_DONE: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = mcw_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mcw_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mcw_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: sv/mcw_dp.sv
// Datapath of the Markov chain walker: edge storage, scan and result register.
module mcw_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  mcw_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mcw_pkg::out_item_t  out_data,
  input  mcw_pkg::ctrl_cmd_t  cmd,
  output mcw_pkg::ctrl_sts_t  sts
);

  // Captured request.
  logic                          op_r;
  logic [mcw_pkg::STATE_W-1:0]   src_r;
  logic [mcw_pkg::STATE_W-1:0]   dst_r;
  logic [mcw_pkg::FRAC_W-1:0]    prob_r;
  logic [mcw_pkg::FRAC_W-1:0]    rand_r;

  // Walk state and scan registers.
  logic [mcw_pkg::STATE_W-1:0]   cur_r, cur_nxt;
  logic [mcw_pkg::CNT_W-1:0]     idx_r, idx_nxt;
  logic [mcw_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [mcw_pkg::SCORE_W-1:0]   lower_r, lower_nxt;
  logic                          nm_r, nm_nxt;
  logic                          rej_r, rej_nxt;
  logic                          out_valid_r, out_valid_nxt;
  mcw_pkg::out_item_t            out_data_r;

  // Per-state header valid bits; a cleared bit reads as an empty list.
  logic [mcw_pkg::NUM_STATES-1:0] hdr_vld_r;

  logic [mcw_pkg::STATE_W-1:0]   hdr_addr;
  logic [mcw_pkg::HDR_W-1:0]     hdr_rdata;
  logic [mcw_pkg::HDR_W-1:0]     hdr_wdata;
  logic                          hdr_we;
  logic [mcw_pkg::CNT_W-1:0]     hdr_cnt;
  logic [mcw_pkg::SCORE_W-1:0]   hdr_sum;
  logic [mcw_pkg::SCORE_W:0]     sum_wide;
  logic [mcw_pkg::SCORE_W-1:0]   sum_sat;
  logic                          list_full;

  logic                          edge_we;
  logic [mcw_pkg::EDGE_ADDR_W-1:0] edge_waddr;
  logic [mcw_pkg::EDGE_ADDR_W-1:0] edge_raddr;
  logic [mcw_pkg::EDGE_W-1:0]    edge_wdata;
  logic [mcw_pkg::EDGE_W-1:0]    edge_rdata;
  logic [mcw_pkg::CNT_W-1:0]     idx_inc;
  logic [mcw_pkg::CNT_W-1:0]     rd_idx;
  logic [mcw_pkg::STATE_W-1:0]   edge_tgt;
  logic [mcw_pkg::SCORE_W-1:0]   edge_cum;
  logic [mcw_pkg::SCORE_W-1:0]   rand_ext;
  logic                          scan_hit;
  logic                          scan_end;

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_data.opcode;
      src_r  <= mcw_pkg::STATE_W'(in_data.source_state);
      dst_r  <= mcw_pkg::STATE_W'(in_data.dest_state);
      prob_r <= in_data.edge_prob;
      rand_r <= in_data.rand_value;
    end
  end

  // Header lookup: the step uses the current state, the append the source.
  assign hdr_addr  = (op_r == mcw_pkg::OP_STEP) ? cur_r : src_r;
  assign hdr_cnt   = hdr_vld_r[hdr_addr] ? hdr_rdata[mcw_pkg::HDR_W-1 -: mcw_pkg::CNT_W]
                                         : '0;
  assign hdr_sum   = hdr_vld_r[hdr_addr] ? hdr_rdata[mcw_pkg::SCORE_W-1:0] : '0;

  // Saturating running sum for an append.
  assign sum_wide  = {1'b0, hdr_sum} + (mcw_pkg::SCORE_W + 1)'(prob_r);
  assign sum_sat   = sum_wide[mcw_pkg::SCORE_W] ? mcw_pkg::SCORE_MAX
                                                : sum_wide[mcw_pkg::SCORE_W-1:0];
  assign list_full = (hdr_cnt >= mcw_pkg::CNT_FULL);

  assign hdr_we    = cmd.eval && (op_r == mcw_pkg::OP_APPEND) && !list_full;
  assign hdr_wdata = {hdr_cnt + mcw_pkg::CNT_W'(1), sum_sat};

  mcw_ram #(
    .WIDTH (mcw_pkg::HDR_W),
    .DEPTH (mcw_pkg::NUM_STATES)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (hdr_we),
    .waddr (src_r),
    .wdata (hdr_wdata),
    .raddr (hdr_addr),
    .rdata (hdr_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_vld_r <= '0;
    end else if (hdr_we) begin
      hdr_vld_r[src_r] <= 1'b1;
    end
  end

  // Edge store: the append writes the next free slot, the scan reads one edge
  // ahead of the compare.
  assign edge_we    = hdr_we;
  assign edge_waddr = {src_r, hdr_cnt[mcw_pkg::EDGE_IDX_W-1:0]};
  assign edge_wdata = {dst_r, sum_sat};
  assign idx_inc    = idx_r + mcw_pkg::CNT_W'(1);
  assign rd_idx     = cmd.eval ? '0 : idx_inc;
  assign edge_raddr = {cur_r, rd_idx[mcw_pkg::EDGE_IDX_W-1:0]};

  mcw_ram #(
    .WIDTH (mcw_pkg::EDGE_W),
    .DEPTH (mcw_pkg::EDGE_DEPTH)
  ) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_waddr),
    .wdata (edge_wdata),
    .raddr (edge_raddr),
    .rdata (edge_rdata)
  );

  // Interval test of the edge that arrived this cycle.
  assign edge_tgt = edge_rdata[mcw_pkg::EDGE_W-1 -: mcw_pkg::STATE_W];
  assign edge_cum = edge_rdata[mcw_pkg::SCORE_W-1:0];
  assign rand_ext = mcw_pkg::SCORE_W'(rand_r);
  assign scan_end = (idx_r >= cnt_r);
  assign scan_hit = !scan_end && (rand_ext > lower_r) && (rand_ext <= edge_cum);

  // Walk, scan and result registers.
  always_comb begin
    cur_nxt   = cur_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    lower_nxt = lower_r;
    nm_nxt    = nm_r;
    rej_nxt   = rej_r;
    if (cmd.eval) begin
      idx_nxt   = '0;
      cnt_nxt   = hdr_cnt;
      lower_nxt = '0;
      nm_nxt    = 1'b0;
      rej_nxt   = (op_r == mcw_pkg::OP_APPEND) && list_full;
    end
    if (cmd.scan) begin
      if (scan_hit) begin
        cur_nxt = edge_tgt;
      end else if (scan_end) begin
        nm_nxt = 1'b1;
      end else begin
        lower_nxt = edge_cum;
        idx_nxt   = idx_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
    end else begin
      cur_r <= cur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    cnt_r   <= cnt_nxt;
    lower_r <= lower_nxt;
    nm_r    <= nm_nxt;
    rej_r   <= rej_nxt;
  end

  // Output register: holds a result until the receiver takes it.
  assign out_valid_nxt = cmd.load_out ? 1'b1 :
                         (out_valid_r && !out_stall) ? 1'b0 : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.next_state    <= 8'(cur_r);
      out_data_r.no_match      <= nm_r;
      out_data_r.load_rejected <= rej_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Status to the controller.
  assign sts.opcode   = op_r;
  assign sts.scan_hit = scan_hit;
  assign sts.scan_end = scan_end;
  assign sts.out_busy = out_valid_r && out_stall;

endmodule

// File: sv/markov_chain_walker_top.sv
// Top level of the Markov chain walker.
//
// Input channel (in_valid, in_stall, in_data): one request per handshake.
// An append request adds an edge with a destination and probability to a
// source state; the state's running sum saturates at the score maximum and a
// full edge list rejects the request. A step request takes a random fraction
// and moves the walk along the first edge of the current state whose
// cumulative interval covers it; with no such edge the state is kept and
// no_match is set.
// Result channel (out_valid, out_stall, out_data): one result per request,
// carrying the current state after it.
// Timing: a request is taken only while the controller is idle. An append
// passes the header, evaluate and done states to a loaded result; a step
// also scans the edges of the current state until one matches or the list
// ends. The scan reads one stored edge per cycle, and the next request is
// taken the cycle after a result loads, once the last one is finished.
// The result sits in an output register; while the receiver stalls, the
// block still accepts and processes the next request and holds its result
// until the register frees up. Reset clears the current state to zero and
// marks every edge list empty at once; no clearing pass is needed.
module markov_chain_walker_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mcw_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mcw_pkg::out_item_t out_data
);

  mcw_pkg::ctrl_cmd_t cmd;
  mcw_pkg::ctrl_sts_t sts;

  mcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mcw_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// File: test/mcw_walk_checker.sv
// Checker that predicts the Markov chain walker's results and compares them on the result channel.
module mcw_walk_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  mcw_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  mcw_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 walks_in_flight,
  output int                 append_count,
  output int                 reject_count,
  output int                 step_count,
  output int                 stuck_count
);

  import mcw_pkg::*;

  // Shadow copy of the chain and of the walk position.
  logic [STATE_W-1:0] walk_pos;
  logic [CNT_W-1:0]   list_len  [NUM_STATES];
  logic [SCORE_W-1:0] state_sum [NUM_STATES];
  logic [STATE_W-1:0] edge_dest [NUM_STATES][MAX_EDGES];
  logic [SCORE_W-1:0] edge_cum  [NUM_STATES][MAX_EDGES];

  // Predicted results, oldest first.
  out_item_t predicted_states[$];

  // Applies one request to the shadow chain and returns the result it must produce.
  function automatic out_item_t walk_chain(input in_item_t req);
    out_item_t           res;
    logic [STATE_W-1:0]  src;
    logic [EDGE_IDX_W-1:0] slot;
    logic [SCORE_W:0]    total;
    logic [SCORE_W-1:0]  lower;
    logic [SCORE_W-1:0]  frac;
    bit                  hit;
    res = '0;
    hit = 1'b0;
    if (req.opcode == OP_APPEND) begin
      src = STATE_W'(req.source_state % NUM_STATES);
      if (list_len[src] >= CNT_FULL) begin
        // A full edge list refuses the new edge and leaves everything as it was.
        res.load_rejected = 1'b1;
      end else begin
        // The running sum saturates at the score maximum.
        slot = list_len[src][EDGE_IDX_W-1:0];
        total = (SCORE_W + 1)'(state_sum[src]) + (SCORE_W + 1)'(req.edge_prob);
        if (total > {1'b0, SCORE_MAX}) total = {1'b0, SCORE_MAX};
        state_sum[src] = total[SCORE_W-1:0];
        edge_dest[src][slot] = STATE_W'(req.dest_state % NUM_STATES);
        edge_cum[src][slot] = total[SCORE_W-1:0];
        list_len[src] = list_len[src] + CNT_W'(1);
      end
    end else begin
      // The first edge whose interval (lower, cumulative] holds the fraction wins.
      frac = SCORE_W'(req.rand_value);
      lower = '0;
      for (int i = 0; i < MAX_EDGES; i++) begin
        if (!hit && i < list_len[walk_pos]) begin
          if (frac > lower && frac <= edge_cum[walk_pos][i]) begin
            walk_pos = edge_dest[walk_pos][i];
            hit = 1'b1;
          end else begin
            lower = edge_cum[walk_pos][i];
          end
        end
      end
      res.no_match = !hit;
    end
    res.next_state = walk_pos;
    return res;
  endfunction

  // Watch both channels: compare each accepted result, then predict each accepted request.
  always @(posedge clk) begin
    out_item_t due_res;
    out_item_t new_res;
    int        errs;
    errs = 0;
    if (!rst_n) begin
      walk_pos = '0;
      for (int s = 0; s < NUM_STATES; s++) begin
        list_len[s] = '0;
        state_sum[s] = '0;
      end
      predicted_states.delete();
      fail_count <= 0;
      walks_in_flight <= 0;
      append_count <= 0;
      reject_count <= 0;
      step_count <= 0;
      stuck_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_states.size() == 0) begin
          $error("result with no request outstanding: next_state %0d", out_data.next_state);
          errs++;
        end else begin
          due_res = predicted_states.pop_front();
          if (out_data.next_state !== due_res.next_state) begin
            $error("next_state: expected %0d, got %0d", due_res.next_state,
                   out_data.next_state);
            errs++;
          end
          if (out_data.no_match !== due_res.no_match) begin
            $error("no_match: expected %0d, got %0d", due_res.no_match, out_data.no_match);
            errs++;
          end
          if (out_data.load_rejected !== due_res.load_rejected) begin
            $error("load_rejected: expected %0d, got %0d", due_res.load_rejected,
                   out_data.load_rejected);
            errs++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        new_res = walk_chain(in_data);
        predicted_states.push_back(new_res);
        if (in_data.opcode == OP_APPEND) begin
          append_count <= append_count + 1;
          if (new_res.load_rejected) reject_count <= reject_count + 1;
        end else begin
          step_count <= step_count + 1;
          if (new_res.no_match) stuck_count <= stuck_count + 1;
        end
      end
      fail_count <= fail_count + errs;
      walks_in_flight <= predicted_states.size();
    end
  end

endmodule

// File: test/tb_markov_chain_walker_top.sv
// Testbench top of the Markov chain walker: request stimulus, result stalls, watchdog and verdict.
module tb_markov_chain_walker_top;

  import mcw_pkg::*;

  localparam int ITEM_TOTAL   = 1950;
  localparam int CALM_ITEMS   = 150;
  localparam int QUIET_LIMIT  = 2000;
  localparam int SETTLE_TICKS = 30;
  localparam int FRAC_ONE     = 1 << PROB_BITS;
  localparam int FRAC_TOP     = (1 << FRAC_W) - 1;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int fail_count;
  int walks_in_flight;
  int append_count;
  int reject_count;
  int step_count;
  int stuck_count;

  // Pacing of both sides; calm turns all idling off for the tail of the run.
  int gap_pct = 0;
  int stall_pct = 0;
  bit calm = 1'b0;
  int stall_left = 0;
  int sent_count = 0;
  int quiet_cycles = 0;
  int visit_order[NUM_STATES];

  always #2 clk = ~clk;

  markov_chain_walker_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  mcw_walk_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .fail_count      (fail_count),
    .walks_in_flight (walks_in_flight),
    .append_count    (append_count),
    .reject_count    (reject_count),
    .step_count      (step_count),
    .stuck_count     (stuck_count)
  );

  // The receiver stalls in bursts of random length.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: too long without any request or result moving ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $error("nothing moved on either channel for %0d cycles", QUIET_LIMIT);
      $display("** markov_chain_walker_top: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_item_t append_req(input int src, input int dst, input int prob);
    in_item_t req;
    req.opcode = OP_APPEND;
    req.source_state = 8'(src);
    req.dest_state = 8'(dst);
    req.edge_prob = 17'(prob);
    req.rand_value = 17'($urandom_range(0, FRAC_TOP));
    return req;
  endfunction

  function automatic in_item_t step_req(input int frac);
    in_item_t req;
    req.opcode = OP_STEP;
    req.source_state = 8'($urandom_range(0, 255));
    req.dest_state = 8'($urandom_range(0, 255));
    req.edge_prob = 17'($urandom_range(0, FRAC_TOP));
    req.rand_value = 17'(frac);
    return req;
  endfunction

  // Mostly proper fractions, some zero, some above 1.0.
  function automatic int pick_fraction();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 5) return 0;
    if (sel < 15) return $urandom_range(FRAC_ONE + 1, FRAC_TOP);
    return $urandom_range(1, FRAC_ONE);
  endfunction

  // Present one request, holding it until the block takes it.
  task automatic send_req(input in_item_t req);
    bit took;
    if (!calm && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    sent_count++;
    if (sent_count >= ITEM_TOTAL - CALM_ITEMS) calm = 1'b1;
  endtask

  // Hold off new requests until every predicted result has come back.
  task automatic drain_walks();
    in_valid <= 1'b0;
    do @(negedge clk); while (walks_in_flight != 0);
    @(posedge clk);
  endtask

  // Occasionally slip in an arbitrary request with every field random.
  task automatic maybe_noise();
    if ($urandom_range(0, 99) < 8) begin
      if ($urandom_range(0, 1) == 0)
        send_req(append_req($urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, FRAC_TOP)));
      else
        send_req(step_req($urandom_range(0, FRAC_TOP)));
    end
  endtask

  // Build edge lists for one group of states, with one exit edge each into the
  // next group, and then walk a while.
  task automatic run_round(input int first, input int span, input int next_first);
    int src;
    int target;
    int exit_p;
    int remaining;
    int n_inner;
    int p;
    for (int k = 0; k < span; k++) begin
      src = visit_order[(first + k) % NUM_STATES];
      target = ($urandom_range(0, 5) == 0) ? $urandom_range(30000, FRAC_ONE - 1) : FRAC_ONE;
      exit_p = target / 8;
      remaining = target - exit_p;
      n_inner = $urandom_range(1, 3);
      for (int e = 0; e < n_inner; e++) begin
        p = (e == n_inner - 1) ? remaining : $urandom_range(0, remaining);
        remaining -= p;
        maybe_noise();
        send_req(append_req(src, visit_order[(first + $urandom_range(0, span - 1)) % NUM_STATES],
                            p));
      end
      send_req(append_req(src, visit_order[(next_first + $urandom_range(0, 1)) % NUM_STATES],
                          exit_p));
    end
    repeat ($urandom_range(8, 30)) begin
      maybe_noise();
      send_req(step_req(pick_fraction()));
    end
  endtask

  initial begin
    int fill_dest[MAX_EDGES];
    int pos;
    int span;
    int rounds;
    int j;
    int tmp;

    fill_dest = '{0, 128, 170, 85, 255, 127, 254, 1};

    // Random order in which states get their edge lists.
    for (int i = 0; i < NUM_STATES; i++) visit_order[i] = i;
    for (int i = NUM_STATES - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = visit_order[i];
      visit_order[i] = visit_order[j];
      visit_order[j] = tmp;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty list, zero fraction, zero-probability edge, interval edges.
    gap_pct = 20;
    stall_pct = 20;
    send_req(step_req(100));
    send_req(append_req(0, 255, 0));
    send_req(append_req(0, 1, FRAC_ONE / 2));
    send_req(step_req(0));
    send_req(step_req(FRAC_ONE / 2));
    send_req(step_req(FRAC_ONE));
    send_req(append_req(1, 255, FRAC_ONE));
    send_req(step_req(FRAC_ONE));
    // Fractions above 1.0 saturate the sum, then the full list refuses more.
    for (int e = 0; e < MAX_EDGES; e++) send_req(append_req(255, fill_dest[e], FRAC_TOP));
    send_req(append_req(255, 85, 1));
    send_req(step_req(FRAC_TOP));
    send_req(step_req(40000));
    send_req(step_req(1));
    send_req(step_req(FRAC_TOP));
    drain_walks();

    // Random: groups of states built in turn, walked between builds.
    pos = 0;
    rounds = 0;
    while (sent_count < ITEM_TOTAL) begin
      if (rounds % 8 == 7) drain_walks();
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 10;
        default: gap_pct = 40;
      endcase
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 10;
        default: stall_pct = 40;
      endcase
      span = $urandom_range(2, 7);
      run_round(pos, span, pos + span);
      pos = (pos + span) % NUM_STATES;
      rounds++;
    end

    drain_walks();
    repeat (SETTLE_TICKS) @(posedge clk);

    $display("Covered %0d appends (%0d refused on a full list) and %0d steps (%0d with no edge).",
             append_count, reject_count, step_count, stuck_count);
    $display("Gaps and stalls came in bursts of 1 to 13 cycles, none in the last %0d requests.",
             CALM_ITEMS);
    if (fail_count == 0) begin
      $display("** markov_chain_walker_top: PASSED **");
    end else begin
      $display("** markov_chain_walker_top: FAILED **");
    end
    $finish;
  end

endmodule
